@@ design/b64lw_pkg.sv @@
// Shared types, constants and the alphabet lookup for the base64 line-wrap encoder.
package b64lw_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int COUNT_W     = 10;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX         = 10'd1023;
  localparam logic [COUNT_W-1:0] WRAP_LENGTH_RESET = 10'd76;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] NEWLINE  = 8'h0A;

  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_ENABLE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_LENGTH = 4'd1;

  // Four encoded characters of one group, first character in slot 0.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            last;
  } group_t;

  typedef struct packed {
    logic               wrap_enable;
    logic [COUNT_W-1:0] wrap_length;
  } wrap_cfg_t;

  typedef struct packed {
    logic [1:0]         char_pos;
    logic               nl_pend;
    logic [COUNT_W-1:0] line_count;
  } back_status_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    logic [7:0] e;
    logic [7:0] c;
    e = {2'b00, idx};
    if (idx < 6'd26) begin
      c = 8'h41 + e;
    end else if (idx < 6'd52) begin
      c = 8'h61 + e - 8'd26;
    end else if (idx < 6'd62) begin
      c = 8'h30 + e - 8'd52;
    end else if (idx == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

@@ design/b64lw_byte_if.sv @@
// Input byte channel: valid/ready with one raw byte and end-of-stream flag.
interface b64lw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/b64lw_char_if.sv @@
// Output character channel: valid/ready with one character and last-result flag.
interface b64lw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

@@ design/b64lw_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and write data.
interface b64lw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [b64lw_pkg::CFG_INDEX_W-1:0]  index;
  logic [b64lw_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/base64_encoder_line_wrap_core.sv @@
// Top level of the base64 encoder with line wrapping: config registers, front, queue, back.
//
//  channel | modport | payload               | role
//  --------+---------+-----------------------+---------------------------------------
//  bytes   | sink    | data_byte, last_byte  | raw bytes in, one per transfer
//  chars   | source  | out_char, out_last    | encoded characters, pads and newlines
//  cfg     | sink    | index, data           | register writes, always ready
//
// Flow: a byte is taken every cycle while the group queue has room. The back end sends one
// character per cycle from a registered output while chars is ready and a group is queued;
// each group is four characters plus newlines; the output port sets the sustained rate.
// Reset (rst, synchronous) empties the queue and clears group position, line count and
// configuration (wrap off, length 76). A stall on chars fills the queue and then drops
// bytes.ready for every byte until the back end pops a group and frees a slot.
module base64_encoder_line_wrap_core #(
  parameter int QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
  input logic          clk,
  input logic          rst,
  b64lw_byte_if.sink   bytes,
  b64lw_char_if.source chars,
  b64lw_cfg_if.sink    cfg
);

  b64lw_pkg::wrap_cfg_t    wrap_cfg;
  b64lw_pkg::group_t       grp_in;
  b64lw_pkg::group_t       grp_out;
  b64lw_pkg::back_status_t back_status;
  logic                    push;
  logic                    pop;
  logic                    q_full;
  logic                    q_empty;

  // Config port never stalls; writes to unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_cfg.wrap_enable <= 1'b0;
      wrap_cfg.wrap_length <= b64lw_pkg::WRAP_LENGTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        b64lw_pkg::REG_WRAP_ENABLE: wrap_cfg.wrap_enable <= cfg.data[0];
        b64lw_pkg::REG_WRAP_LENGTH: wrap_cfg.wrap_length <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front: grouping and alphabet lookup.
  b64lw_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .q_full (q_full),
    .push   (push),
    .grp    (grp_in)
  );

  // Queue decouples byte intake from character output.
  b64lw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr    (grp_in),
    .pop   (pop),
    .rd    (grp_out),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: character sequencing and newline insertion.
  b64lw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (wrap_cfg),
    .grp     (grp_out),
    .q_empty (q_empty),
    .pop     (pop),
    .chars   (chars),
    .status  (back_status)
  );

  // Queue occupancy is consistent.
  a_queue_flags: assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // A pending newline always follows a cleared line count.
  a_nl_count: assert property (@(posedge clk) disable iff (rst)
    back_status.nl_pend |-> (back_status.line_count == '0))
    else $error("newline pending with non-zero line count");

  // With no group queued the back end sits at the start of a group.
  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> (back_status.char_pos == 2'd0 && !back_status.nl_pend))
    else $error("back end mid-group with empty queue");

  // Popping a group only happens while one is queued.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("group popped from empty queue");

endmodule

@@ design/b64lw_front.sv @@
// Front end: collects bytes into groups of three and encodes each group to four characters.
module b64lw_front (
  input  logic              clk,
  input  logic              rst,
  b64lw_byte_if.sink        bytes,
  input  logic              q_full,
  output logic              push,
  output b64lw_pkg::group_t grp
);

  logic [1:0] held;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic       take;
  logic       finish;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;

  assign bytes.ready = !q_full;
  assign take        = bytes.valid && bytes.ready;
  assign finish      = (held == 2'd2) || bytes.last_byte;
  assign push        = take && finish;

  // Missing bytes of a short group read as zero.
  always_comb begin
    b0 = (held == 2'd0) ? bytes.data_byte : pend0;
    b1 = (held == 2'd0) ? 8'd0 : ((held == 2'd1) ? bytes.data_byte : pend1);
    b2 = (held == 2'd2) ? bytes.data_byte : 8'd0;
    grp.chars[0] = b64lw_pkg::enc_char(b0[7:2]);
    grp.chars[1] = b64lw_pkg::enc_char({b0[1:0], b1[7:4]});
    grp.chars[2] = (held != 2'd0) ? b64lw_pkg::enc_char({b1[3:0], b2[7:6]})
                                  : b64lw_pkg::PAD_CHAR;
    grp.chars[3] = (held == 2'd2) ? b64lw_pkg::enc_char(b2[5:0]) : b64lw_pkg::PAD_CHAR;
    grp.last     = bytes.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
    end else if (take) begin
      held <= finish ? 2'd0 : held + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !finish) begin
      if (held == 2'd0) begin
        pend0 <= bytes.data_byte;
      end else begin
        pend1 <= bytes.data_byte;
      end
    end
  end

endmodule

@@ design/b64lw_fifo.sv @@
// Short group queue between front and back ends.
module b64lw_fifo #(
  parameter int DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64lw_pkg::group_t wr,
  input  logic              pop,
  output b64lw_pkg::group_t rd,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64lw_pkg::group_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/b64lw_back.sv @@
// Back end: one char per cycle unless stalled; inserts newlines and keeps the line count.
module b64lw_back (
  input  logic                    clk,
  input  logic                    rst,
  input  b64lw_pkg::wrap_cfg_t    cfg,
  input  b64lw_pkg::group_t       grp,
  input  logic                    q_empty,
  output logic                    pop,
  b64lw_char_if.source            chars,
  output b64lw_pkg::back_status_t status
);

  logic [1:0]                    pos;
  logic                          nl_pend;
  logic [b64lw_pkg::COUNT_W-1:0] line_count;
  logic                          out_valid;
  logic [7:0]                    out_char;
  logic                          out_last;

  logic                          out_free;
  logic                          emit;
  logic [b64lw_pkg::COUNT_W-1:0] cnt;
  logic                          final_char;
  logic                          nl_hit;

  assign out_free = !out_valid || chars.ready;
  assign emit     = out_free && !q_empty;

  always_comb begin
    if (!cfg.wrap_enable || line_count == b64lw_pkg::COUNT_MAX) begin
      cnt = line_count;
    end else begin
      cnt = line_count + 1'b1;
    end
    final_char = (pos == 2'd3) && grp.last;
    nl_hit     = cfg.wrap_enable && (cnt == cfg.wrap_length) && !final_char;
  end

  // Group leaves the queue with its fourth character, or with the newline after it.
  assign pop = emit && (pos == 2'd3) && (nl_pend || !nl_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 2'd0;
      nl_pend    <= 1'b0;
      line_count <= '0;
      out_valid  <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      if (nl_pend) begin
        nl_pend <= 1'b0;
        pos     <= pos + 2'd1;
      end else if (nl_hit) begin
        nl_pend    <= 1'b1;
        line_count <= '0;
      end else begin
        pos        <= pos + 2'd1;
        line_count <= final_char ? '0 : cnt;
      end
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (nl_pend) begin
        out_char <= b64lw_pkg::NEWLINE;
        out_last <= (pos == 2'd3);
      end else begin
        out_char <= grp.chars[pos];
        out_last <= (pos == 2'd3) && !nl_hit;
      end
    end
  end

  assign chars.valid    = out_valid;
  assign chars.out_char = out_char;
  assign chars.out_last = out_last;

  assign status.char_pos   = pos;
  assign status.nl_pend    = nl_pend;
  assign status.line_count = line_count;

endmodule
